### hdl/dpsg_pkg.sv
package dpsg_pkg;

  // Number of tone generator chips behind the bus port (1 or 2).
  localparam int NUM_CHIPS   = 2;
  // Hold count loaded when an audible volume is written (1 to 15; loaded as at most 7).
  localparam int HOLD_RELOAD = 6;

  localparam int CHIP_AW = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;

  localparam logic [2:0] HOLD_VAL = (HOLD_RELOAD > 7) ? 3'd7 : 3'(HOLD_RELOAD);

  localparam logic [15:0] WINDOW_MASK = 16'hE000;
  localparam logic [15:0] WINDOW_BASE = 16'hA000;
  localparam logic [3:0]  SILENT      = 4'd15;
  localparam logic [1:0]  NOISE_CH    = 2'd3;

  // Bus offsets inside the window.
  localparam logic [2:0] OFS_LATCH = 3'd0;
  localparam logic [2:0] OFS_PSG0  = 3'd1;
  localparam logic [2:0] OFS_PSG1  = 3'd2;
  localparam logic [2:0] OFS_DAC   = 3'd3;

  localparam logic [7:0] DAC_RESET = 8'd128;

  typedef logic [CHIP_AW-1:0] chip_idx_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LATCH,
    OP_PSG,
    OP_DAC
  } op_t;

  // Complete register state of one chip; one memory word per chip.
  typedef struct packed {
    logic [2:0]       sel;
    logic [2:0][9:0]  tone;
    logic [2:0]       noise;
    logic [3:0][3:0]  att;
    logic [3:0][3:0]  low;
    logic [3:0][2:0]  hold;
  } chip_state_t;

  localparam chip_state_t RESET_STATE = '{
    sel:   3'd0,
    tone:  '0,
    noise: 3'd0,
    att:   {4{SILENT}},
    low:   {4{SILENT}},
    hold:  '0
  };

  // What one chip write reports.
  typedef struct packed {
    logic       changed;
    logic [1:0] channel;
    logic [9:0] period;
    logic [3:0] volume;
    logic [3:0] min_volume;
    logic [2:0] hold;
  } psg_res_t;

endpackage

### hdl/dual_psg_register_writer_unit.sv
// Bus write decoder for a pair of programmable tone generator chips and an 8-bit DAC. Each
// item on the input is one sound CPU write; only addresses in the 0xA000 window
// (address & 0xE000) are decoded, by the low three address bits: offset 0 latches a byte,
// offsets 1 and 2 pass the latched byte to chip 0 or chip 1, offset 3 sets the DAC level,
// and every other write changes nothing. Every item gives exactly one result item that
// reports the chip register touched (changed set in tuser) together with the DAC level
// after the write; when changed is clear the chip fields are zero. The block takes one
// item per clock cycle unless a stalled output holds it. An accepted item sits in a
// decode stage while the per-chip register state is read from a small synchronous
// memory with a registered read, and is then loaded into the output register, from
// which its result item is offered. A write that follows straight behind another
// to the same chip takes the freshly updated state from a bypass register instead of the
// memory. The output register lets the next item into the decode stage while a result
// waits to be taken; once both stages are full, a stalled output holds the input.
module dual_psg_register_writer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // address[15:0], value[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // chip[0], channel[2:1], period[12:3], volume[16:13],
                                  // min_volume[20:17], hold[23:21], dac_level[31:24]
  output logic        out_tuser   // changed
);
  import dpsg_pkg::*;

  // Input fields.
  logic [15:0] in_address;
  logic [7:0]  in_value;
  logic [2:0]  in_offset;
  logic        in_window;
  logic        in_accept;
  op_t         in_op;
  chip_idx_t   in_chip;

  // Stage 1: decoded item waiting for its chip state.
  logic        s1_valid_r;
  op_t         s1_op_r;
  logic [7:0]  s1_value_r;
  chip_idx_t   s1_chip_r;
  logic        s1_advance;
  logic        s1_wr;

  // Bypass of the last chip state written.
  logic        fwd_hit_r;
  chip_state_t fwd_state_r;

  logic [7:0]  byte_latch_r;
  logic [7:0]  byte_latch_nxt;
  logic [7:0]  dac_r;
  logic [7:0]  dac_nxt;

  chip_state_t rd_state;
  chip_state_t cur_state;
  chip_state_t new_state;
  psg_res_t    upd_res;
  psg_res_t    res_nxt;

  // Output register.
  logic        out_valid_r;
  psg_res_t    out_res_r;
  logic        out_chip_r;
  logic [7:0]  out_dac_r;

  assign in_address = in_tdata[15:0];
  assign in_value   = in_tdata[23:16];
  assign in_offset  = in_address[2:0];
  assign in_window  = (in_address & WINDOW_MASK) == WINDOW_BASE;

  // The decode for the second chip only applies when that chip exists.
  always_comb begin
    in_op   = OP_NONE;
    in_chip = chip_idx_t'(in_offset == OFS_PSG1);
    if (in_window) begin
      unique case (in_offset)
        OFS_LATCH: in_op = OP_LATCH;
        OFS_PSG0:  in_op = OP_PSG;
        OFS_PSG1:  in_op = (NUM_CHIPS > 1) ? OP_PSG : OP_NONE;
        OFS_DAC:   in_op = OP_DAC;
        default:   in_op = OP_NONE;
      endcase
    end
  end

  assign s1_advance = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_advance;
  assign in_accept  = in_tvalid && in_tready;
  assign s1_wr      = s1_advance && (s1_op_r == OP_PSG);

  dpsg_state_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept && (in_op == OP_PSG)),
    .rd_addr (in_chip),
    .rd_data (rd_state),
    .wr_en   (s1_wr),
    .wr_addr (s1_chip_r),
    .wr_data (new_state)
  );

  // A read issued in the same cycle as a write to the same chip returns the old word,
  // so such an item takes the bypass copy instead.
  assign cur_state = fwd_hit_r ? fwd_state_r : rd_state;

  dpsg_chip_update u_upd (
    .cur  (cur_state),
    .data (byte_latch_r),
    .nxt  (new_state),
    .res  (upd_res)
  );

  always_comb begin
    byte_latch_nxt = byte_latch_r;
    dac_nxt        = dac_r;
    res_nxt        = '0;
    case (s1_op_r)
      OP_LATCH: byte_latch_nxt = s1_value_r;
      OP_DAC:   dac_nxt        = s1_value_r;
      OP_PSG:   res_nxt        = upd_res;
      default:  res_nxt        = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      fwd_hit_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      byte_latch_r <= '0;
      dac_r        <= DAC_RESET;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
        fwd_hit_r  <= s1_wr && (in_op == OP_PSG) && (in_chip == s1_chip_r);
      end else if (s1_advance) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_r  <= 1'b1;
        byte_latch_r <= byte_latch_nxt;
        dac_r        <= dac_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r    <= in_op;
      s1_value_r <= in_value;
      s1_chip_r  <= in_chip;
    end
    if (s1_wr) begin
      fwd_state_r <= new_state;
    end
    if (s1_advance) begin
      out_res_r  <= res_nxt;
      out_chip_r <= res_nxt.changed & s1_chip_r[0];
      out_dac_r  <= dac_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.changed;
  assign out_tdata  = {out_dac_r, out_res_r.hold, out_res_r.min_volume,
                       out_res_r.volume, out_res_r.period, out_res_r.channel, out_chip_r};

endmodule

### hdl/dpsg_state_ram.sv
module dpsg_state_ram (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rd_en,
  input  dpsg_pkg::chip_idx_t    rd_addr,
  output dpsg_pkg::chip_state_t  rd_data,
  input  logic                   wr_en,
  input  dpsg_pkg::chip_idx_t    wr_addr,
  input  dpsg_pkg::chip_state_t  wr_data
);
  import dpsg_pkg::*;

  chip_state_t              mem [NUM_CHIPS];
  chip_state_t              rd_q_r;
  logic [NUM_CHIPS-1:0]     vld_r;
  logic                     rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // An entry never written reads as the reset state of a chip.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : RESET_STATE;

endmodule

### hdl/dpsg_chip_update.sv
module dpsg_chip_update (
  input  dpsg_pkg::chip_state_t  cur,
  input  logic [7:0]             data,
  output dpsg_pkg::chip_state_t  nxt,
  output dpsg_pkg::psg_res_t     res
);
  import dpsg_pkg::*;

  logic [1:0] reg_idx;
  logic       is_vol;
  logic [3:0] vol;

  always_comb begin
    nxt     = cur;
    vol     = data[3:0];
    reg_idx = data[7] ? data[6:5] : cur.sel[2:1];
    is_vol  = data[7] ? data[4] : cur.sel[0];
    res     = '0;

    if (data[7]) begin
      // Latch byte: selects the register and carries its low bits.
      nxt.sel = {data[6:5], data[4]};
      if (!data[4]) begin
        if (reg_idx == NOISE_CH) begin
          nxt.noise = data[2:0];
        end else begin
          nxt.tone[reg_idx] = {cur.tone[reg_idx][9:4], data[3:0]};
        end
      end else begin
        nxt.att[reg_idx] = vol;
        if (vol < cur.low[reg_idx]) begin
          nxt.low[reg_idx] = vol;
        end
        if (vol < SILENT) begin
          nxt.hold[reg_idx] = HOLD_VAL;
        end
      end
      res.changed = 1'b1;
    end else if (!is_vol) begin
      // Data byte: upper six period bits, or the noise setting.
      if (reg_idx == NOISE_CH) begin
        nxt.noise = data[2:0];
      end else begin
        nxt.tone[reg_idx] = {data[5:0], cur.tone[reg_idx][3:0]};
      end
      res.changed = 1'b1;
    end

    if (res.changed) begin
      res.channel = reg_idx;
      case (reg_idx)
        2'd0:    res.period = nxt.tone[0];
        2'd1:    res.period = nxt.tone[1];
        2'd2:    res.period = nxt.tone[2];
        default: res.period = {7'd0, nxt.noise};
      endcase
      res.volume     = nxt.att[reg_idx];
      res.min_volume = nxt.low[reg_idx];
      res.hold       = nxt.hold[reg_idx];
    end
  end

endmodule
